@@ src/joystick_axis_conditioner_defines.svh @@
// assertion macros shared by the joystick axis conditioner rtl
// no dependencies; taken in by the files that carry assertions
`ifndef JOYSTICK_AXIS_CONDITIONER_DEFINES_SVH
`define JOYSTICK_AXIS_CONDITIONER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define JAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define JAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/jac_pkg.sv @@
// shared types, constants and arithmetic helpers of the joystick axis conditioner
// no dependencies
`default_nettype none

package jac_pkg;

    localparam int AXES            = 4;
    localparam int BUTTONS         = 6;
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_CAL_SAMPLES = 32;
    localparam int MAG_W           = 16;
    localparam int STEP_W          = 6;
    localparam int NORM_W          = 11;
    localparam int TIME_W          = 32;
    localparam int DZ_W            = 12;
    localparam int INTERVAL_W      = 16;
    localparam int SHIFT_W         = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int OUT_W           = 72;

    localparam int AXIS_S1_Y = 1;
    localparam int AXIS_S2_Y = 3;
    localparam int BTN_S1A     = 0;
    localparam int BTN_S1CLICK = 4;

    // divide by 200 as multiply and shift, exact for magnitudes below 2^16
    localparam int STEP_RECIP_W = 17;
    localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = 17'd83887;
    localparam int STEP_SHIFT = 24;
    localparam logic [MAG_W-1:0] STEP_POS_LIM = 16'd31;
    localparam logic [MAG_W-1:0] STEP_NEG_LIM = 16'd32;
    localparam logic [MAG_W-1:0] NORM_LIM     = 16'd1000;

    localparam logic [DZ_W-1:0]       RST_MENU_DZ   = 12'd250;
    localparam logic [DZ_W-1:0]       RST_MENU_REL  = 12'd120;
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL  = 16'd180;
    localparam logic [DZ_W-1:0]       RST_STEP_DZ   = 12'd60;
    localparam logic [SHIFT_W-1:0]    RST_SHIFT     = 3'd3;

    typedef enum logic {
        OP_CAL = 1'b0,
        OP_RUN = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MENU_DEADZONE   = 3'd0,
        CFG_MENU_RELEASE    = 3'd1,
        CFG_REPEAT_INTERVAL = 3'd2,
        CFG_STEP_DEADZONE   = 3'd3,
        CFG_FILTER_SHIFT    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [DZ_W-1:0]       menu_deadzone;
        logic [DZ_W-1:0]       menu_release;
        logic [INTERVAL_W-1:0] repeat_interval_ms;
        logic [DZ_W-1:0]       step_deadzone;
        logic [SHIFT_W-1:0]    filter_shift;
    } t_cfg;

    typedef struct packed {
        logic               load;
        t_opcode            op;
        logic               cal_last;
        logic [SHIFT_W-1:0] shift;
    } t_lane_ctl;

    typedef struct packed {
        t_opcode            op;
        logic [BUTTONS-1:0] buttons_n;
        logic [TIME_W-1:0]  now_ms;
    } t_item;

    typedef struct packed {
        logic                     menu_up;
        logic                     menu_down;
        logic                     menu_select;
        logic [BUTTONS-1:0]       buttons_held;
        logic signed [STEP_W-1:0] step_stick1;
        logic signed [STEP_W-1:0] step_stick2;
        logic signed [NORM_W-1:0] norm_stick1_x;
        logic signed [NORM_W-1:0] norm_stick1_y;
        logic signed [NORM_W-1:0] norm_stick2_x;
        logic signed [NORM_W-1:0] norm_stick2_y;
        logic                     calibrated;
    } t_result;

    // offset magnitude to step value, deadzone then truncating divide by 200
    function automatic logic signed [STEP_W-1:0] f_step(
        input logic             neg,
        input logic [MAG_W-1:0] mag,
        input logic [DZ_W-1:0]  dz
    );
        logic [MAG_W+STEP_RECIP_W-1:0] prod;
        logic [MAG_W-1:0]              q;
        logic [STEP_W-1:0]             r;
        prod = mag * STEP_RECIP;
        q    = MAG_W'(prod[MAG_W+STEP_RECIP_W-1:STEP_SHIFT]);
        if (mag < MAG_W'(dz)) begin
            r = '0;
        end else if (neg) begin
            r = (q >= STEP_NEG_LIM) ? STEP_W'(-STEP_NEG_LIM) : STEP_W'(-q);
        end else begin
            r = (q >= STEP_POS_LIM) ? STEP_W'(STEP_POS_LIM) : STEP_W'(q);
        end
        return $signed(r);
    endfunction

    // half the offset toward zero, saturated
    function automatic logic signed [NORM_W-1:0] f_norm(
        input logic             neg,
        input logic [MAG_W-1:0] mag
    );
        logic [MAG_W-1:0]  h;
        logic [NORM_W-1:0] lim;
        h   = mag >> 1;
        lim = (h > NORM_LIM) ? NORM_W'(NORM_LIM) : NORM_W'(h);
        return $signed(neg ? NORM_W'(-lim) : lim);
    endfunction

endpackage

`default_nettype wire

@@ src/jac_lane.sv @@
// one axis lane: calibration accumulator, centre and shift-based low-pass filter
// depends on jac_pkg
`default_nettype none

module jac_lane #(
    parameter int SAMPLE_BITS = jac_pkg::DEF_SAMPLE_BITS,
    parameter int CAL_SAMPLES = jac_pkg::DEF_CAL_SAMPLES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  jac_pkg::t_lane_ctl     i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_raw,
    output logic [SAMPLE_BITS-1:0] o_filt,
    output logic [SAMPLE_BITS-1:0] o_center
);
    import jac_pkg::*;

    localparam int CAL_LOG     = $clog2(CAL_SAMPLES);
    localparam int SUM_W       = SAMPLE_BITS + CAL_LOG;
    localparam int RECIP_SHIFT = SUM_W + CAL_LOG;
    localparam int RECIP_W     = SUM_W + 2;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    logic [SAMPLE_BITS-1:0] r_filt, n_filt;
    logic [SAMPLE_BITS-1:0] r_center, n_center;
    logic [SUM_W-1:0]       r_sum, n_sum;

    logic [SUM_W-1:0]        sum_add;
    logic [PROD_W-1:0]       prod;
    logic [SAMPLE_BITS-1:0]  mean;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [SAMPLE_BITS:0] delta;

    assign sum_add = r_sum + SUM_W'(i_raw);
    assign prod    = PROD_W'(sum_add) * PROD_W'(RECIP);
    assign mean    = prod[RECIP_SHIFT +: SAMPLE_BITS];
    assign diff    = $signed({1'b0, i_raw}) - $signed({1'b0, r_filt});
    assign delta   = diff >>> i_ctl.shift;

    always_comb begin
        n_filt   = r_filt;
        n_center = r_center;
        n_sum    = r_sum;
        if (i_ctl.load) begin
            if (i_ctl.op == OP_CAL) begin
                if (i_ctl.cal_last) begin
                    n_center = mean;
                    n_filt   = mean;
                    n_sum    = '0;
                end else begin
                    n_sum = sum_add;
                end
            end else begin
                n_filt = r_filt + delta[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt   <= '0;
            r_center <= '0;
            r_sum    <= '0;
        end else begin
            r_filt   <= n_filt;
            r_center <= n_center;
            r_sum    <= n_sum;
        end
    end

    assign o_filt   = r_filt;
    assign o_center = r_center;

endmodule

`default_nettype wire

@@ src/jac_merge.sv @@
// merge stage: axis offsets, menu events with hysteresis and repeat, buttons,
// step and normalised outputs, and the output register; depends on jac_pkg
`default_nettype none
`include "joystick_axis_conditioner_defines.svh"

module jac_merge #(
    parameter int SAMPLE_BITS = jac_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_load,
    input  jac_pkg::t_item                               i_item,
    input  jac_pkg::t_cfg                                i_cfg,
    input  logic                                         i_cal_done,
    input  logic [jac_pkg::AXES-1:0][SAMPLE_BITS-1:0]    i_filt,
    input  logic [jac_pkg::AXES-1:0][SAMPLE_BITS-1:0]    i_center,
    output logic                                         o_ready,
    output logic                                         o_res_valid,
    input  logic                                         i_res_ready,
    output jac_pkg::t_result                             o_res
);
    import jac_pkg::*;

    localparam int CW = ((SAMPLE_BITS > DZ_W) ? SAMPLE_BITS : DZ_W) + 2;

    logic r_b_valid, n_b_valid;
    t_item r_b_item;
    logic r_out_valid, n_out_valid;
    t_result r_out, n_res;

    logic r_held_down, n_held_down;
    logic r_held_up, n_held_up;
    logic [TIME_W-1:0]  r_last, n_last;
    logic [BUTTONS-1:0] r_btn_now, n_btn_now;
    logic [BUTTONS-1:0] r_btn_prev, n_btn_prev;

    logic out_free;
    logic b_adv;
    logic signed [SAMPLE_BITS:0] off [AXES];
    logic [SAMPLE_BITS:0]        mag_w [AXES];
    logic [MAG_W-1:0]            mag [AXES];
    logic                        neg [AXES];
    logic signed [CW-1:0] d_c, dz_c, rel_c;
    logic [TIME_W-1:0]    elapsed;
    logic                 time_ok;
    logic [BUTTONS-1:0]   rising;
    logic                 pulse_up, pulse_down, sel;

    assign out_free = !r_out_valid || i_res_ready;
    assign b_adv    = r_b_valid && out_free;
    assign o_ready  = !r_b_valid || out_free;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            off[a]   = $signed({1'b0, i_filt[a]}) - $signed({1'b0, i_center[a]});
            neg[a]   = off[a][SAMPLE_BITS];
            mag_w[a] = neg[a] ? (SAMPLE_BITS+1)'(-off[a]) : (SAMPLE_BITS+1)'(off[a]);
            mag[a]   = MAG_W'(mag_w[a][SAMPLE_BITS-1:0]);
        end
    end

    assign d_c     = CW'(off[AXIS_S1_Y]);
    assign dz_c    = $signed(CW'(i_cfg.menu_deadzone));
    assign rel_c   = $signed(CW'(i_cfg.menu_release));
    assign elapsed = r_b_item.now_ms - r_last;
    assign time_ok = elapsed > TIME_W'(i_cfg.repeat_interval_ms);

    always_comb begin
        n_held_down = r_held_down;
        n_held_up   = r_held_up;
        n_last      = r_last;
        n_btn_now   = r_btn_now;
        n_btn_prev  = r_btn_prev;
        pulse_up    = 1'b0;
        pulse_down  = 1'b0;
        sel         = 1'b0;
        rising      = '0;
        if (b_adv && r_b_item.op == OP_RUN) begin
            n_btn_prev = r_btn_now;
            n_btn_now  = ~r_b_item.buttons_n;
            if (d_c > dz_c) begin
                if (!r_held_down || time_ok) begin
                    n_held_down = 1'b1;
                    n_last      = r_b_item.now_ms;
                    pulse_down  = 1'b1;
                end
            end else if (d_c < rel_c) begin
                n_held_down = 1'b0;
            end
            if (d_c < -dz_c) begin
                if (!r_held_up || time_ok) begin
                    n_held_up = 1'b1;
                    n_last    = r_b_item.now_ms;
                    pulse_up  = 1'b1;
                end
            end else if (d_c > -rel_c) begin
                n_held_up = 1'b0;
            end
            rising = n_btn_now & ~r_btn_now;
            sel    = rising[BTN_S1A] | rising[BTN_S1CLICK];
        end
    end

    always_comb begin
        n_res.menu_up       = pulse_up;
        n_res.menu_down     = pulse_down;
        n_res.menu_select   = sel;
        n_res.buttons_held  = n_btn_now;
        n_res.step_stick1   = f_step(neg[AXIS_S1_Y], mag[AXIS_S1_Y], i_cfg.step_deadzone);
        n_res.step_stick2   = f_step(neg[AXIS_S2_Y], mag[AXIS_S2_Y], i_cfg.step_deadzone);
        n_res.norm_stick1_x = f_norm(neg[0], mag[0]);
        n_res.norm_stick1_y = f_norm(neg[1], mag[1]);
        n_res.norm_stick2_x = f_norm(neg[2], mag[2]);
        n_res.norm_stick2_y = f_norm(neg[3], mag[3]);
        n_res.calibrated    = i_cal_done;
    end

    always_comb begin
        n_b_valid = r_b_valid;
        if (i_load) begin
            n_b_valid = 1'b1;
        end else if (b_adv) begin
            n_b_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (b_adv) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_held_down <= 1'b0;
            r_held_up   <= 1'b0;
            r_last      <= '0;
            r_btn_now   <= '0;
            r_btn_prev  <= '0;
        end else begin
            r_b_valid   <= n_b_valid;
            r_out_valid <= n_out_valid;
            r_held_down <= n_held_down;
            r_held_up   <= n_held_up;
            r_last      <= n_last;
            r_btn_now   <= n_btn_now;
            r_btn_prev  <= n_btn_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b_item <= i_item;
        end
        if (b_adv) begin
            r_out <= n_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    `JAC_ASSERT_IMP(a_pulse_excl, i_clk, i_rst_n, r_out_valid, !(r_out.menu_up && r_out.menu_down), "menu up and down in one transaction")
    `JAC_ASSERT_IMP(a_held_excl, i_clk, i_rst_n, 1'b1, !(r_held_down && r_held_up), "both directions held")
    `JAC_ASSERT_NXT(a_cal_quiet, i_clk, i_rst_n, b_adv && r_b_item.op == OP_CAL, !r_out.menu_up && !r_out.menu_down && !r_out.menu_select, "menu event from calibration")
    `JAC_ASSERT_IMP(a_stall_block, i_clk, i_rst_n, r_b_valid && r_out_valid && !i_res_ready, !o_ready && !b_adv, "merge stage moved while output stalled")

endmodule

`default_nettype wire

@@ src/joystick_axis_conditioner.sv @@
// top level of the joystick axis conditioner: stream ports, configuration
// registers, calibration counter, four axis lanes and the merge stage
// depends on jac_pkg, jac_lane, jac_merge
`default_nettype none
`include "joystick_axis_conditioner_defines.svh"

// Takes one transaction per clock while tready is high and returns one result
// per transaction. Each axis has its own lane that updates its filter or
// calibration sum in the cycle the transaction is accepted; once the output
// register can take a result, the merge stage works out the menu events, steps
// and normalised axes from the lane values and loads the output register.
// tready drops only when the merge stage and the output register are both
// full and the output side is stalled. The configuration port is always ready;
// registers should be written only while no transaction is in flight.

module joystick_axis_conditioner #(
    parameter int SAMPLE_BITS = jac_pkg::DEF_SAMPLE_BITS,
    parameter int CAL_SAMPLES = jac_pkg::DEF_CAL_SAMPLES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // sample_stick1_x, sample_stick1_y, sample_stick2_x, sample_stick2_y,
    // buttons_n, now_ms, zero fill
    input  logic [((4*SAMPLE_BITS+jac_pkg::BUTTONS+jac_pkg::TIME_W+7)/8)*8-1:0]
                                               i_s_axis_tdata,
    // opcode
    input  logic                               i_s_axis_tuser,
    // master stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // menu_up, menu_down, menu_select, buttons_held, step_stick1, step_stick2,
    // norm_stick1_x, norm_stick1_y, norm_stick2_x, norm_stick2_y, calibrated, zero fill
    output logic [jac_pkg::OUT_W-1:0]          o_m_axis_tdata,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [jac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jac_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import jac_pkg::*;

    localparam int CNT_W   = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam int BTN_LSB = AXES * SAMPLE_BITS;
    localparam int NOW_LSB = BTN_LSB + BUTTONS;
    localparam int RES_W   = $bits(t_result);

    t_cfg r_cfg, n_cfg;
    logic [CNT_W-1:0] r_cal_cnt, n_cal_cnt;
    logic r_cal_done, n_cal_done;

    logic      s_accept;
    t_opcode   op;
    logic      cal_last;
    t_lane_ctl lane_ctl;
    t_item     item;
    t_result   res;
    logic      merge_ready;

    logic [AXES-1:0][SAMPLE_BITS-1:0] filt;
    logic [AXES-1:0][SAMPLE_BITS-1:0] center;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = merge_ready;
    assign s_accept        = i_s_axis_tvalid && merge_ready;
    assign op              = t_opcode'(i_s_axis_tuser);
    assign cal_last        = (r_cal_cnt == CNT_W'(CAL_SAMPLES - 1));

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MENU_DEADZONE:   n_cfg.menu_deadzone      = i_cfg_data[DZ_W-1:0];
                CFG_MENU_RELEASE:    n_cfg.menu_release       = i_cfg_data[DZ_W-1:0];
                CFG_REPEAT_INTERVAL: n_cfg.repeat_interval_ms = i_cfg_data[INTERVAL_W-1:0];
                CFG_STEP_DEADZONE:   n_cfg.step_deadzone      = i_cfg_data[DZ_W-1:0];
                CFG_FILTER_SHIFT:    n_cfg.filter_shift       = i_cfg_data[SHIFT_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        n_cal_cnt  = r_cal_cnt;
        n_cal_done = r_cal_done;
        if (s_accept && op == OP_CAL) begin
            if (cal_last) begin
                n_cal_cnt  = '0;
                n_cal_done = 1'b1;
            end else begin
                n_cal_cnt = r_cal_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.menu_deadzone      <= RST_MENU_DZ;
            r_cfg.menu_release       <= RST_MENU_REL;
            r_cfg.repeat_interval_ms <= RST_INTERVAL;
            r_cfg.step_deadzone      <= RST_STEP_DZ;
            r_cfg.filter_shift       <= RST_SHIFT;
            r_cal_cnt                <= '0;
            r_cal_done               <= 1'b0;
        end else begin
            r_cfg      <= n_cfg;
            r_cal_cnt  <= n_cal_cnt;
            r_cal_done <= n_cal_done;
        end
    end

    assign lane_ctl.load     = s_accept;
    assign lane_ctl.op       = op;
    assign lane_ctl.cal_last = cal_last;
    assign lane_ctl.shift    = r_cfg.filter_shift;

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        jac_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CAL_SAMPLES (CAL_SAMPLES)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (lane_ctl),
            .i_raw    (i_s_axis_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .o_filt   (filt[g]),
            .o_center (center[g])
        );
    end

    assign item.op        = op;
    assign item.buttons_n = i_s_axis_tdata[BTN_LSB +: BUTTONS];
    assign item.now_ms    = i_s_axis_tdata[NOW_LSB +: TIME_W];

    jac_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_accept),
        .i_item      (item),
        .i_cfg       (r_cfg),
        .i_cal_done  (r_cal_done),
        .i_filt      (filt),
        .i_center    (center),
        .o_ready     (merge_ready),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = OUT_W'({res.calibrated,
                                    res.norm_stick2_y, res.norm_stick2_x,
                                    res.norm_stick1_y, res.norm_stick1_x,
                                    res.step_stick2, res.step_stick1,
                                    res.buttons_held,
                                    res.menu_select, res.menu_down, res.menu_up});

    `JAC_ASSERT_NXT(a_cal_round, i_clk, i_rst_n, s_accept && op == OP_CAL && cal_last, r_cal_cnt == '0 && r_cal_done, "calibration round did not close")
    `JAC_ASSERT_IMP(a_res_width, i_clk, i_rst_n, 1'b1, RES_W <= OUT_W, "result wider than tdata")

endmodule

`default_nettype wire
